// ----- design/ntg_pkg.sv -----
// Shared types and constants for the synthetic traffic generator.
package ntg_pkg;

  localparam int RANK_W      = 8;
  localparam int DIM_W       = 9;
  localparam int STAMP_BITS  = 32;
  localparam int MAX_NODES   = 256;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int DIV_STEPS   = 8;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 144;

  typedef enum logic [2:0] {
    PAT_UNIFORM    = 3'd0,
    PAT_COMPLEMENT = 3'd1,
    PAT_TRANSPOSE  = 3'd2,
    PAT_BITREV     = 3'd3,
    PAT_SHUFFLE    = 3'd4,
    PAT_TORNADO    = 3'd5,
    PAT_NEIGHBOR   = 3'd6,
    PAT_UPPERLEFT  = 3'd7
  } pat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN    = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_NODE_COUNT = 3'd2,
    CFG_MESH_W     = 3'd3,
    CFG_MESH_H     = 3'd4,
    CFG_OWN_RANK   = 3'd5,
    CFG_INDEX_BITS = 3'd6
  } cfg_idx_t;

  // Which division the shared divider runs
  typedef enum logic [1:0] {
    DIV_RANK_BY_W = 2'd0,   // x = rank % W, q = rank / W
    DIV_Q_BY_H    = 2'd1,   // y = q % H
    DIV_RND_BY_N  = 2'd2    // uniform pick = rand_dest % (N-1)
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul;
    logic     dest;
    logic     commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- design/ntg_ram.sv -----
// Generic single-port-write RAM with registered read.
module ntg_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/ntg_div.sv -----
// Restoring divider, one quotient bit per cycle, 8-bit dividend.
module ntg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ntg_pkg::RANK_W-1:0] dividend,
  input  logic [ntg_pkg::DIM_W-1:0]  divisor,
  output logic                      done,
  output logic [ntg_pkg::RANK_W-1:0] quot,
  output logic [ntg_pkg::RANK_W-1:0] rem
);
  import ntg_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [RANK_W-1:0] dvd_r;
  logic [RANK_W-1:0] rem_r;
  logic [DIM_W-1:0]  dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIM_W-1:0]  trial;
  logic              fits;
  logic [RANK_W-1:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[RANK_W-1]};
  assign fits    = (trial >= dsr_r);
  assign rem_nxt = fits ? RANK_W'(trial - dsr_r) : trial[RANK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RANK_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

// ----- design/ntg_datapath.sv -----
// Datapath: config registers, destination math, FIFO, counters, output register.
module ntg_datapath #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ntg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ntg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [ntg_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  ntg_pkg::ctl_cmd_t                cmd,
  output ntg_pkg::dp_sts_t                 sts,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ntg_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ntg_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W  = RANK_W + STAMP_BITS;
  localparam int PAD_W  = OUT_TDATA_W - (2 + RANK_W + 2 * STAMP_BITS + 64);

  // config registers
  pat_t              pat_r;
  logic [63:0]       thr_r;
  logic [DIM_W-1:0]  n_r;
  logic [DIM_W-1:0]  w_r;
  logic [DIM_W-1:0]  h_r;
  logic [RANK_W-1:0] rank_r;
  logic [3:0]        bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= PAT_UNIFORM;
      thr_r  <= '0;
      n_r    <= DIM_W'(256);
      w_r    <= DIM_W'(16);
      h_r    <= DIM_W'(16);
      rank_r <= '0;
      bits_r <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN:    pat_r  <= pat_t'(cfg_data[2:0]);
        CFG_THRESHOLD:  thr_r  <= cfg_data;
        CFG_NODE_COUNT: n_r    <= cfg_data[DIM_W-1:0];
        CFG_MESH_W:     w_r    <= cfg_data[DIM_W-1:0];
        CFG_MESH_H:     h_r    <= cfg_data[DIM_W-1:0];
        CFG_OWN_RANK:   rank_r <= cfg_data[RANK_W-1:0];
        CFG_INDEX_BITS: bits_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [DIM_W-1:0]  n_eff, w_eff, h_eff, half_n;
  logic [RANK_W-1:0] nm1;
  logic [3:0]        b_eff;
  logic [2:0]        shamt;

  assign n_eff  = (n_r < DIM_W'(2)) ? DIM_W'(2) :
                  (n_r > DIM_W'(MAX_NODES)) ? DIM_W'(MAX_NODES) : n_r;
  assign w_eff  = (w_r == '0) ? DIM_W'(1) : w_r;
  assign h_eff  = (h_r == '0) ? DIM_W'(1) : h_r;
  assign nm1    = RANK_W'(n_eff - DIM_W'(1));
  assign half_n = n_eff >> 1;
  assign b_eff  = (bits_r == 4'd0) ? 4'd1 : (bits_r > 4'd8) ? 4'd8 : bits_r;
  assign shamt  = 3'(4'd8 - b_eff);

  // latched item
  logic                  inj_r, ready_r, rvalid_r;
  logic [RANK_W-1:0]     rdest_r;
  logic [STAMP_BITS-1:0] rstamp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inj_r    <= (in_tdata[63:0] < thr_r);
      rdest_r  <= in_tdata[71:64];
      ready_r  <= in_tdata[72];
      rvalid_r <= in_tdata[73];
      rstamp_r <= in_tdata[105:74];
    end
  end

  // shared divider
  div_sel_t          sel_r;
  logic [RANK_W-1:0] div_dvd, div_q, div_rem;
  logic [DIM_W-1:0]  div_dsr;
  logic              div_done;
  logic [RANK_W-1:0] x_r, q_r, y_r, rmod_r;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_RANK_BY_W: begin div_dvd = rank_r;  div_dsr = w_eff;        end
      DIV_Q_BY_H:    begin div_dvd = q_r;     div_dsr = h_eff;        end
      DIV_RND_BY_N:  begin div_dvd = rdest_r; div_dsr = {1'b0, nm1};  end
      default:       begin div_dvd = rdest_r; div_dsr = {1'b0, nm1};  end
    endcase
  end

  ntg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      sel_r <= cmd.div_sel;
    end
    if (div_done) begin
      case (sel_r)
        DIV_RANK_BY_W: begin x_r <= div_rem; q_r <= div_q; end
        DIV_Q_BY_H:    y_r    <= div_rem;
        default:       rmod_r <= div_rem;
      endcase
    end
  end

  // mesh coordinate moves
  logic [RANK_W-1:0] offx, offy, tx, ty, nx, ny, ux, uy, xx, yy;
  logic [DIM_W-1:0]  tx_sum, ty_sum, nx_sum, ny_sum;

  assign offx   = (w_eff >= DIM_W'(2)) ? RANK_W'((w_eff >> 1) - DIM_W'(1)) : '0;
  assign offy   = (h_eff >= DIM_W'(2)) ? RANK_W'((h_eff >> 1) - DIM_W'(1)) : '0;
  assign tx_sum = {1'b0, x_r} + {1'b0, offx};
  assign ty_sum = {1'b0, y_r} + {1'b0, offy};
  assign tx     = (tx_sum >= w_eff) ? RANK_W'(tx_sum - w_eff) : tx_sum[RANK_W-1:0];
  assign ty     = (ty_sum >= h_eff) ? RANK_W'(ty_sum - h_eff) : ty_sum[RANK_W-1:0];
  assign nx_sum = {1'b0, x_r} + DIM_W'(1);
  assign ny_sum = {1'b0, y_r} + DIM_W'(1);
  assign nx     = (nx_sum == w_eff) ? '0 : nx_sum[RANK_W-1:0];
  assign ny     = (ny_sum == h_eff) ? '0 : ny_sum[RANK_W-1:0];
  assign ux     = (x_r == '0) ? RANK_W'(w_eff - DIM_W'(1)) : x_r - 1'b1;
  assign uy     = (y_r == '0) ? RANK_W'(h_eff - DIM_W'(1)) : y_r - 1'b1;

  always_comb begin
    case (pat_r)
      PAT_TORNADO:  begin xx = tx; yy = ty; end
      PAT_NEIGHBOR: begin xx = nx; yy = ny; end
      default:      begin xx = ux; yy = uy; end
    endcase
  end

  // one multiplier: x*W for transpose, y'*W for the mesh moves
  logic [RANK_W-1:0]        mul_a, add_a, prod_r, add_r;
  logic [RANK_W+DIM_W-1:0]  mul_full;

  assign mul_a    = (pat_r == PAT_TRANSPOSE) ? x_r : yy;
  assign add_a    = (pat_r == PAT_TRANSPOSE) ? q_r : xx;
  assign mul_full = {{DIM_W{1'b0}}, mul_a} * {{RANK_W{1'b0}}, w_eff};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= mul_full[RANK_W-1:0];
      add_r  <= add_a;
    end
  end

  // bit patterns
  logic [RANK_W-1:0] rev, d_uni, d_comp, d_rev, d_shuf, d_mesh, dest_nxt, dest_r;

  always_comb begin
    for (int k = 0; k < RANK_W; k++) begin
      rev[k] = rank_r[RANK_W-1-k];
    end
  end

  assign d_uni  = (rmod_r >= rank_r) ? rmod_r + 1'b1 : rmod_r;
  assign d_comp = ~rank_r & (8'hFF >> shamt);
  assign d_rev  = rev >> shamt;
  assign d_shuf = {rank_r[RANK_W-2:0], 1'b0}
                - (({1'b0, rank_r} >= half_n) ? nm1 : '0);
  assign d_mesh = prod_r + add_r;

  always_comb begin
    unique case (pat_r)
      PAT_UNIFORM:    dest_nxt = d_uni;
      PAT_COMPLEMENT: dest_nxt = d_comp;
      PAT_BITREV:     dest_nxt = d_rev;
      PAT_SHUFFLE:    dest_nxt = d_shuf;
      default:        dest_nxt = d_mesh;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.dest) begin
      dest_r <= dest_nxt;
    end
  end

  // pending FIFO
  logic [PTR_W-1:0]      head_r, tail_r, head_nxt, tail_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [ENT_W-1:0]      head_ent;
  logic                  push, pop, full;
  logic [STAMP_BITS-1:0] cyc_r;

  assign full = (fill_r == FILL_W'(QUEUE_DEPTH));

  ntg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r),
    .wdata ({cyc_r, dest_r}),
    .raddr (head_r),
    .rdata (head_ent)
  );

  // counters and result
  logic [31:0]           cnt_r, cnt_nxt;
  logic [63:0]           lat_r, lat_nxt;
  logic [STAMP_BITS-1:0] lat_inc;
  logic                  sv, ovf;
  logic [RANK_W-1:0]     sd;
  logic [STAMP_BITS-1:0] ss;

  always_comb begin
    sv   = 1'b0;
    sd   = '0;
    ss   = '0;
    ovf  = 1'b0;
    push = 1'b0;
    pop  = 1'b0;
    if (inj_r) begin
      if (ready_r) begin
        sv = 1'b1;
        sd = dest_r;
        ss = cyc_r;
      end else if (!full) begin
        push = cmd.commit;
      end else begin
        ovf = 1'b1;
      end
    end else if ((fill_r != '0) && ready_r) begin
      sv  = 1'b1;
      sd  = head_ent[RANK_W-1:0];
      ss  = head_ent[ENT_W-1:RANK_W];
      pop = cmd.commit;
    end
  end

  assign head_nxt = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_nxt = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign fill_nxt = push ? fill_r + 1'b1 : pop ? fill_r - 1'b1 : fill_r;
  assign lat_inc  = cyc_r - rstamp_r;
  assign cnt_nxt  = rvalid_r ? cnt_r + 32'd1 : cnt_r;
  assign lat_nxt  = rvalid_r ? lat_r + {{(64 - STAMP_BITS){1'b0}}, lat_inc} : lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      cyc_r  <= '0;
      cnt_r  <= '0;
      lat_r  <= '0;
    end else if (cmd.commit) begin
      if (push) tail_r <= tail_nxt;
      if (pop)  head_r <= head_nxt;
      fill_r <= fill_nxt;
      cyc_r  <= cyc_r + 1'b1;
      cnt_r  <= cnt_nxt;
      lat_r  <= lat_nxt;
    end
  end

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {{PAD_W{1'b0}}, lat_nxt, cnt_nxt, ovf, ss, sd, sv};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

endmodule

// ----- design/ntg_ctrl.sv -----
// Controller: sequences the divider runs, destination and commit per request.
module ntg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ntg_pkg::dp_sts_t  sts,
  output ntg_pkg::ctl_cmd_t cmd
);
  import ntg_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_STX  = 10'b0000000010,
    S_WX   = 10'b0000000100,
    S_STY  = 10'b0000001000,
    S_WY   = 10'b0000010000,
    S_STR  = 10'b0000100000,
    S_WR   = 10'b0001000000,
    S_MUL  = 10'b0010000000,
    S_DEST = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.div_sel   = DIV_RANK_BY_W;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_STX;
        end
      end
      S_STX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RANK_BY_W;
        state_nxt     = S_WX;
      end
      S_WX:  if (sts.div_done) state_nxt = S_STY;
      S_STY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_Q_BY_H;
        state_nxt     = S_WY;
      end
      S_WY:  if (sts.div_done) state_nxt = S_STR;
      S_STR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RND_BY_N;
        state_nxt     = S_WR;
      end
      S_WR:  if (sts.div_done) state_nxt = S_MUL;
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DEST;
      end
      S_DEST: begin
        cmd.dest  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ----- design/noc_synthetic_traffic_generator_core.sv -----
// Top level: per-node synthetic traffic source and sink.
// Sequencing: one request at a time; each takes three runs of the shared 8-step divider plus load,
//   multiply, destination select and a commit that waits for a free output slot.
// Reset: rst_n is synchronous, active low; config returns to its defaults, FIFO pointers,
//   cycle counter and statistics clear; FIFO contents are not cleared.
module noc_synthetic_traffic_generator_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ntg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ntg_pkg::CFG_DATA_W-1:0]   cfg_data,
  // tick requests
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] rand_inject, [71:64] rand_dest, [72] net_ready, [73] recv_valid,
  // [105:74] recv_stamp, [111:106] zero
  input  logic [ntg_pkg::IN_TDATA_W-1:0]   in_tdata,
  // per-tick results
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] send_valid, [8:1] send_dest, [40:9] send_stamp, [41] queue_overflow,
  // [73:42] received_count, [137:74] latency_sum, [143:138] zero
  output logic [ntg_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import ntg_pkg::*;

  ctl_cmd_t ctl_cmd;
  dp_sts_t  dp_sts;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  // Controller walks each request through: load, rank/W, q%H, rand%(N-1),
  // multiply, destination select, then commit once the output slot is free.
  ntg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (dp_sts),
    .cmd      (ctl_cmd)
  );

  // Datapath holds config, the divider, the pending FIFO, the counters and
  // the output register; a result waits there while the next request computes.
  ntg_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (ctl_cmd),
    .sts        (dp_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  // one request in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while previous one in flight");

  // a commit always leaves a result in the output register
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |=> out_tvalid)
    else $error("commit did not produce a result");

  // a dropped flit is never reported as sent
  a_drop_not_sent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[41]))
    else $error("flit both sent and dropped");

  // divider is never restarted in the cycle it finishes
  a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
    dp_sts.div_done |-> !ctl_cmd.div_start)
    else $error("divider restarted while completing");
`endif

endmodule
